// ===== design/sdc_pkg.sv =====
// sdc_pkg: word types, codes and constants for the sd spi command sender
// no dependencies
`timescale 1ns / 1ps

package sdc_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  command_byte;
    logic [31:0] argument;
    logic [7:0]  received_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] transmit_byte;
    logic [7:0] response;
    logic [1:0] status;
    logic       last;
  } out_word_t;

  // input actions
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_RX    = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SEND     = 2'd0;
  localparam logic [1:0] KIND_EXCHANGE = 2'd1;
  localparam logic [1:0] KIND_DONE     = 2'd2;

  // finish status
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_READY   = 2'd1;
  localparam logic [1:0] ST_NO_RESPONSE = 2'd2;

  // register indexes
  localparam logic REG_READY_TICKS = 1'b0;
  localparam logic REG_POLL_LIMIT  = 1'b1;

  // phase codes
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_DISCARD = 3'd1;
  localparam logic [2:0] PH_READY   = 3'd2;
  localparam logic [2:0] PH_STUFF   = 3'd3;
  localparam logic [2:0] PH_POLL    = 3'd4;

  localparam logic [7:0] CMD_GO_IDLE   = 8'h40;
  localparam logic [7:0] CMD_IF_COND   = 8'h48;
  localparam logic [7:0] CMD_STOP      = 8'h4C;
  localparam logic [7:0] CRC_GO_IDLE   = 8'h95;
  localparam logic [7:0] CRC_IF_COND   = 8'h87;
  localparam logic [7:0] BYTE_IDLE     = 8'hFF;
  localparam logic [7:0] READY_TICKS_RST = 8'd50;
  localparam logic [7:0] POLL_LIMIT_RST  = 8'd10;

  localparam int unsigned MaxWords = 7;
  localparam int unsigned CntW     = 3;

endpackage

// ===== design/sd_spi_command_sender.sv =====
// sd_spi_command_sender: sd card spi-mode command sequencer with r1 response polling
// depends on sdc_pkg
`timescale 1ns / 1ps
//
// usage:
//   input channel (in_valid_i / in_ready_o / in_word_i) takes start, received
//   byte and tick words. each accepted word is decoded in the same cycle and
//   its results (zero to seven words) are loaded into an output queue.
//   output channel (out_valid_o / out_ready_i / out_word_o) drains that queue
//   one word per cycle from a register while out_ready_i is high, so the first
//   result appears in the cycle after acceptance.
//   a word that gives one result sustains one word per cycle; a command frame
//   (seven results) holds off the input until its last result is being taken,
//   and the next word is taken together with the seventh result.
//   a new input word is taken while the last queued result is being taken.
//   when the receiver stalls the queue holds and the input waits.
//   config channel (cfg_valid_i / cfg_ready_o) is always ready; index 0 is
//   ready_ticks, index 1 is poll_limit.
//   reset: phase idle, counters and held command cleared, queue empty,
//   ready_ticks 50, poll_limit 10.
//
module sd_spi_command_sender
  import sdc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  logic [7:0]  ready_ticks_q, poll_limit_q;
  logic [2:0]  phase_q, phase_d;
  logic [7:0]  countdown_q, countdown_d;
  logic [7:0]  poll_cnt_q, poll_cnt_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [31:0] arg_q, arg_d;

  out_word_t       queue_q [MaxWords];
  out_word_t       new_w   [MaxWords];
  logic [CntW-1:0] cnt_q, new_n;

  logic in_acc, out_acc;
  logic [7:0] crc, poll_left, poll_init;

  out_word_t w_xchg, w_send;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (cnt_q == '0) || ((cnt_q == CntW'(1)) && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_acc     = out_valid_o && out_ready_i;
  assign out_word_o  = queue_q[0];

  assign poll_init = (poll_limit_q == 8'd0) ? 8'd1 : poll_limit_q;
  assign poll_left = (poll_cnt_q != 8'd0) ? poll_cnt_q - 8'd1 : 8'd0;

  always_comb begin
    crc = 8'd0;
    if (cmd_q == CMD_GO_IDLE) crc = CRC_GO_IDLE;
    if (cmd_q == CMD_IF_COND) crc = CRC_IF_COND;
  end

  always_comb begin
    w_xchg = '{kind: KIND_EXCHANGE, transmit_byte: BYTE_IDLE, response: 8'd0,
               status: ST_OK, last: 1'b1};
    w_send = '{kind: KIND_SEND, transmit_byte: 8'd0, response: 8'd0,
               status: ST_OK, last: 1'b0};
  end

  always_comb begin
    phase_d     = phase_q;
    countdown_d = countdown_q;
    poll_cnt_d  = poll_cnt_q;
    cmd_d       = cmd_q;
    arg_d       = arg_q;
    new_n       = '0;
    for (int i = 0; i < MaxWords; i++) new_w[i] = w_xchg;
    case (in_word_i.action)
      ACT_START: begin
        cmd_d       = in_word_i.command_byte;
        arg_d       = in_word_i.argument;
        countdown_d = ready_ticks_q;
        phase_d     = PH_DISCARD;
        new_n       = CntW'(1);
      end
      ACT_TICK: begin
        if (countdown_q != 8'd0) countdown_d = countdown_q - 8'd1;
      end
      ACT_RX: begin
        case (phase_q)
          PH_DISCARD: begin
            phase_d = PH_READY;
            new_n   = CntW'(1);
          end
          PH_READY: begin
            if (in_word_i.received_byte == BYTE_IDLE) begin
              for (int i = 0; i < 6; i++) new_w[i] = w_send;
              new_w[0].transmit_byte = cmd_q;
              new_w[1].transmit_byte = arg_q[31:24];
              new_w[2].transmit_byte = arg_q[23:16];
              new_w[3].transmit_byte = arg_q[15:8];
              new_w[4].transmit_byte = arg_q[7:0];
              new_w[5].transmit_byte = crc;
              new_n = CntW'(MaxWords);
              if (cmd_q == CMD_STOP) begin
                phase_d = PH_STUFF;
              end else begin
                poll_cnt_d = poll_init;
                phase_d    = PH_POLL;
              end
            end else if (countdown_q == 8'd0) begin
              phase_d = PH_IDLE;
              new_w[0] = '{kind: KIND_DONE, transmit_byte: 8'd0, response: BYTE_IDLE,
                           status: ST_NOT_READY, last: 1'b1};
              new_n = CntW'(1);
            end else begin
              new_n = CntW'(1);
            end
          end
          PH_STUFF: begin
            poll_cnt_d = poll_init;
            phase_d    = PH_POLL;
            new_n      = CntW'(1);
          end
          PH_POLL: begin
            new_n = CntW'(1);
            if (!in_word_i.received_byte[7]) begin
              phase_d  = PH_IDLE;
              new_w[0] = '{kind: KIND_DONE, transmit_byte: 8'd0,
                           response: in_word_i.received_byte, status: ST_OK, last: 1'b1};
            end else begin
              poll_cnt_d = poll_left;
              if (poll_left == 8'd0) begin
                phase_d  = PH_IDLE;
                new_w[0] = '{kind: KIND_DONE, transmit_byte: 8'd0,
                             response: in_word_i.received_byte,
                             status: ST_NO_RESPONSE, last: 1'b1};
              end
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_ticks_q <= READY_TICKS_RST;
      poll_limit_q  <= POLL_LIMIT_RST;
      phase_q       <= PH_IDLE;
      countdown_q   <= 8'd0;
      poll_cnt_q    <= 8'd0;
      cmd_q         <= 8'd0;
      arg_q         <= 32'd0;
      cnt_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_READY_TICKS) ready_ticks_q <= cfg_data_i;
        if (cfg_index_i == REG_POLL_LIMIT) poll_limit_q <= cfg_data_i;
      end
      if (in_acc) begin
        phase_q     <= phase_d;
        countdown_q <= countdown_d;
        poll_cnt_q  <= poll_cnt_d;
        cmd_q       <= cmd_d;
        arg_q       <= arg_d;
        cnt_q       <= new_n;
      end else if (out_acc) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxWords; i++) queue_q[i] <= new_w[i];
    end else if (out_acc) begin
      for (int i = 0; i < MaxWords - 1; i++) queue_q[i] <= queue_q[i+1];
    end
  end

endmodule
